/* rtl/effs_pkg.sv */
// Shared types and constants for the escaped flag frame splitter.
`default_nettype none
package effs_pkg;

    localparam int SYMBOL_BITS     = 4;
    localparam int MASK_BITS       = 1 << SYMBOL_BITS;
    localparam int CFG_IDX_BITS    = 2;
    localparam int CFG_DATA_BITS   = MASK_BITS;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic [SYMBOL_BITS-1:0]   t_symbol;
    typedef logic [MASK_BITS-1:0]     t_follow_mask;
    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_BITS-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_FLAG   = 2'd0;
    localparam t_cfg_idx CFG_ESCAPE = 2'd1;
    localparam t_cfg_idx CFG_FOLLOW = 2'd2;

    localparam t_symbol      FLAG_RESET   = 4'd15;
    localparam t_symbol      ESCAPE_RESET = 4'd14;
    localparam t_follow_mask FOLLOW_RESET = 16'h0990;

    typedef struct packed {
        t_symbol lead_sym;
        logic    lead_first;
        logic    lead_last;
        logic    pair;
        t_symbol tail_sym;
        logic    tail_last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage
`default_nettype wire

/* rtl/effs_if.sv */
// Valid/ready stream interfaces for input symbols and frame output symbols.
`default_nettype none
interface effs_in_if;
    logic             valid;
    logic             ready;
    effs_pkg::t_symbol in_symbol;

    modport source (output valid, output in_symbol, input ready);
    modport sink   (input valid, input in_symbol, output ready);
endinterface

interface effs_out_if;
    logic             valid;
    logic             ready;
    effs_pkg::t_symbol out_symbol;
    logic             frame_first;
    logic             frame_last;

    modport source (output valid, output out_symbol, output frame_first, output frame_last,
                    input ready);
    modport sink   (input valid, input out_symbol, input frame_first, input frame_last,
                    output ready);
endinterface
`default_nettype wire

/* rtl/effs_front.sv */
// Front end: configuration registers, frame hunting state and symbol classification.
`default_nettype none
module effs_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    effs_in_if.sink                   i_in,
    input  wire logic                 i_cfg_we,
    input  wire effs_pkg::t_cfg_idx   i_cfg_index,
    input  wire effs_pkg::t_cfg_data  i_cfg_data,
    input  wire effs_pkg::t_queue_status i_qstat,
    output logic                      o_push,
    output effs_pkg::t_entry          o_entry
);
    import effs_pkg::*;

    t_symbol      r_flag;
    t_symbol      r_escape;
    t_follow_mask r_follow;

    t_symbol r_prev,    n_prev;
    logic    r_start,   n_start;
    logic    r_pending, n_pending;
    logic    r_inside,  n_inside;

    t_symbol sym;
    logic    accept;
    logic    closes;
    logic    follow_ok;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign sym        = i_in.in_symbol;
    assign closes     = (sym == r_flag) && (r_prev != r_escape);
    assign follow_ok  = r_follow[sym];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag   <= FLAG_RESET;
            r_escape <= ESCAPE_RESET;
            r_follow <= FOLLOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FLAG:   r_flag   <= i_cfg_data[SYMBOL_BITS-1:0];
                CFG_ESCAPE: r_escape <= i_cfg_data[SYMBOL_BITS-1:0];
                CFG_FOLLOW: r_follow <= i_cfg_data[MASK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_prev    = r_prev;
        n_start   = r_start;
        n_pending = r_pending;
        n_inside  = r_inside;
        o_push    = 1'b0;
        o_entry   = '{lead_sym: sym, lead_first: 1'b0, lead_last: closes,
                      pair: 1'b0, tail_sym: sym, tail_last: closes};
        if (accept) begin
            n_prev = sym;
            if (r_inside) begin
                o_push = 1'b1;
                if (closes) begin
                    n_inside = 1'b0;
                    n_start  = 1'b1;
                end
            end else if (r_pending && follow_ok) begin
                o_push             = 1'b1;
                n_pending          = 1'b0;
                o_entry.lead_sym   = r_flag;
                o_entry.lead_first = 1'b1;
                o_entry.lead_last  = 1'b0;
                o_entry.pair       = 1'b1;
                if (closes) begin
                    n_start = 1'b1;
                end else begin
                    n_inside = 1'b1;
                end
            end else begin
                n_pending = (sym == r_flag) && (r_start || (r_prev != r_escape));
                n_start   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_start   <= 1'b1;
            r_pending <= 1'b0;
            r_inside  <= 1'b0;
        end else begin
            r_prev    <= n_prev;
            r_start   <= n_start;
            r_pending <= n_pending;
            r_inside  <= n_inside;
        end
    end

endmodule
`default_nettype wire

/* rtl/effs_queue.sv */
// Short FIFO of classified entries between the front end and the output stage.
`default_nettype none
module effs_queue #(
    parameter int DEPTH = effs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire effs_pkg::t_entry    i_entry,
    input  wire logic                i_pop,
    output effs_pkg::t_entry         o_entry,
    output effs_pkg::t_queue_status  o_status
);
    import effs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_entry        = r_mem[r_rptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + PW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

/* rtl/effs_back.sv */
// Output stage: drains queue entries and sends an opening flag pair as two transactions.
`default_nettype none
module effs_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire effs_pkg::t_entry        i_entry,
    input  wire effs_pkg::t_queue_status i_qstat,
    output logic                         o_pop,
    effs_out_if.source                   o_out
);
    import effs_pkg::*;

    logic    r_valid,     n_valid;
    t_symbol r_sym,       n_sym;
    logic    r_first,     n_first;
    logic    r_last,      n_last;
    logic    r_sec_valid, n_sec_valid;
    t_symbol r_sec_sym,   n_sec_sym;
    logic    r_sec_last,  n_sec_last;
    logic    out_free;

    assign out_free = !r_valid || o_out.ready;
    assign o_pop    = out_free && !r_sec_valid && !i_qstat.empty;

    assign o_out.valid       = r_valid;
    assign o_out.out_symbol  = r_sym;
    assign o_out.frame_first = r_first;
    assign o_out.frame_last  = r_last;

    always_comb begin
        n_valid     = r_valid;
        n_sym       = r_sym;
        n_first     = r_first;
        n_last      = r_last;
        n_sec_valid = r_sec_valid;
        n_sec_sym   = r_sec_sym;
        n_sec_last  = r_sec_last;
        if (out_free) begin
            if (r_sec_valid) begin
                n_valid     = 1'b1;
                n_sym       = r_sec_sym;
                n_first     = 1'b0;
                n_last      = r_sec_last;
                n_sec_valid = 1'b0;
            end else if (!i_qstat.empty) begin
                n_valid     = 1'b1;
                n_sym       = i_entry.lead_sym;
                n_first     = i_entry.lead_first;
                n_last      = i_entry.lead_last;
                n_sec_valid = i_entry.pair;
                n_sec_sym   = i_entry.tail_sym;
                n_sec_last  = i_entry.tail_last;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_sec_valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_sec_valid <= n_sec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_first    <= n_first;
        r_last     <= n_last;
        r_sec_sym  <= n_sec_sym;
        r_sec_last <= n_sec_last;
    end

endmodule
`default_nettype wire

/* rtl/escaped_flag_frame_splitter_core.sv */
// Top level of the escaped flag frame splitter.
//
// Cuts flag-delimited frames out of a stream of 4-bit stuffed symbols and
// forwards only frame symbols, flags included, with frame_first on the opening
// flag and frame_last on the closing flag. One input symbol is accepted per
// clock; the front end decides each symbol in the cycle it is accepted and
// queues its results, so input acceptance stalls only when the QUEUE_DEPTH
// entry queue is full. An accepted start produces two output transactions
// (opening flag and follower) through the output register; all other frame
// symbols take one. Output valid rises only after an accepted symbol has
// passed through the queue and the output register. Configuration writes take
// effect on the next clock and are expected only while no symbol is in flight.
`default_nettype none
module escaped_flag_frame_splitter_core #(
    parameter int QUEUE_DEPTH = effs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    effs_in_if.sink                  i_in,
    effs_out_if.source               o_out,
    input  wire logic                i_cfg_we,
    input  wire effs_pkg::t_cfg_idx  i_cfg_index,
    input  wire effs_pkg::t_cfg_data i_cfg_data
);
    import effs_pkg::*;

    t_entry        push_entry;
    t_entry        head_entry;
    t_queue_status qstat;
    logic          push;
    logic          pop;

    effs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    effs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (qstat)
    );

    effs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (head_entry),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

/* rtl/effs_checker.sv */
// Port-level assertions for the frame splitter core and their bind.
`default_nettype none
module effs_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire effs_pkg::t_symbol i_out_symbol,
    input wire logic              i_out_first,
    input wire logic              i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_symbol) && $stable(i_out_first) &&
            $stable(i_out_last))
        else $error("output transaction changed while stalled");

    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_first && i_out_last))
        else $error("opening flag marked as closing flag");

    a_follower_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_first |=> i_out_valid && !i_out_first)
        else $error("follower of opening flag not presented next cycle");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("core not idle after reset");

endmodule

bind escaped_flag_frame_splitter_core effs_checker u_effs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_symbol (o_out.out_symbol),
    .i_out_first  (o_out.frame_first),
    .i_out_last   (o_out.frame_last)
);
`default_nettype wire

/* tb/escaped_flag_frame_splitter_core_test.sv */
// Self-checking testbench for escaped_flag_frame_splitter_core: a behavioral frame splitter predicts the output transactions.
`timescale 1ns / 100ps
module escaped_flag_frame_splitter_core_test;
    import effs_pkg::*;

    localparam t_cfg_idx CFG_SPARE = 2'd3;
    localparam int HOLD_CYCLES = 250;

    typedef struct packed {
        t_symbol sym;
        logic    is_first;
        logic    is_last;
    } t_frame_sym;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_index;
    t_cfg_data i_cfg_data;

    effs_in_if  in_ch();
    effs_out_if out_ch();

    escaped_flag_frame_splitter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    t_symbol      symbol_feed[$];
    t_frame_sym   frame_expect[$];
    int           sym_errors;

    t_symbol      cur_flag;
    t_symbol      cur_escape;
    t_follow_mask cur_follow;
    t_symbol      last_sym;
    logic         fresh_start;
    logic         cand_pending;
    logic         in_frame;

    logic         in_taken;
    int           send_gap;
    int           stall_left;
    int           hold_left;
    int           hold_reqs;
    int           hold_seen;
    logic         send_idle_on;
    logic         recv_idle_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("** escaped_flag_frame_splitter_core: FAILED **");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic queue_symbol(input t_symbol s);
        symbol_feed.insert(symbol_feed.size(), s);
    endtask

    task automatic add_expected(input t_symbol s, input logic first, input logic last);
        t_frame_sym item;
        item = '{sym: s, is_first: first, is_last: last};
        frame_expect.insert(frame_expect.size(), item);
    endtask

    task automatic split_symbol(input t_symbol s);
        logic closes;
        closes = (s == cur_flag) && (last_sym != cur_escape);
        if (in_frame) begin
            add_expected(s, 1'b0, closes);
            if (closes) begin
                in_frame    = 1'b0;
                fresh_start = 1'b1;
            end
        end else if (cand_pending && cur_follow[s]) begin
            cand_pending = 1'b0;
            add_expected(cur_flag, 1'b1, 1'b0);
            add_expected(s, 1'b0, closes);
            if (closes) fresh_start = 1'b1;
            else in_frame = 1'b1;
        end else begin
            cand_pending = (s == cur_flag) && (fresh_start || last_sym != cur_escape);
            fresh_start  = 1'b0;
        end
        last_sym = s;
    endtask

    always @(posedge i_clk) begin
        t_frame_sym want;
        if (!i_rst_n) begin
            cur_flag     = FLAG_RESET;
            cur_escape   = ESCAPE_RESET;
            cur_follow   = FOLLOW_RESET;
            last_sym     = '0;
            fresh_start  = 1'b1;
            cand_pending = 1'b0;
            in_frame     = 1'b0;
            in_taken    <= 1'b0;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FLAG:   cur_flag = i_cfg_data[SYMBOL_BITS-1:0];
                    CFG_ESCAPE: cur_escape = i_cfg_data[SYMBOL_BITS-1:0];
                    CFG_FOLLOW: cur_follow = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) split_symbol(in_ch.in_symbol);
            if (out_ch.valid && out_ch.ready) begin
                if (frame_expect.size() == 0) begin
                    sym_errors++;
                    if (sym_errors <= 10)
                        $display("unexpected output transaction: sym=%0d first=%0b last=%0b",
                                 out_ch.out_symbol, out_ch.frame_first, out_ch.frame_last);
                end else begin
                    want = frame_expect.pop_front();
                    if (out_ch.out_symbol !== want.sym || out_ch.frame_first !== want.is_first
                            || out_ch.frame_last !== want.is_last) begin
                        sym_errors++;
                        if (sym_errors <= 10)
                            $display("mismatch at %0t: expected sym=%0d first=%0b last=%0b, got sym=%0d first=%0b last=%0b",
                                     $realtime, want.sym, want.is_first, want.is_last,
                                     out_ch.out_symbol, out_ch.frame_first, out_ch.frame_last);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid     <= 1'b0;
            in_ch.in_symbol <= '0;
            send_gap        <= 0;
        end else if (!in_ch.valid || in_taken) begin
            if (send_gap != 0) begin
                in_ch.valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end else if (symbol_feed.size() != 0) begin
                in_ch.valid     <= 1'b1;
                in_ch.in_symbol <= symbol_feed.pop_front();
                send_gap        <= send_idle_on ? idle_len() : 0;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            hold_seen    <= 0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen    <= hold_reqs;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if (recv_idle_on && $urandom_range(0, 2) == 0) stall_left <= idle_len();
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        while (symbol_feed.size() != 0 || in_ch.valid || frame_expect.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_config(input t_symbol f, input t_symbol e, input t_follow_mask m);
        write_reg(CFG_FLAG, {12'($urandom_range(0, 4095)), f});
        write_reg(CFG_ESCAPE, {12'($urandom_range(0, 4095)), e});
        write_reg(CFG_FOLLOW, m);
        @(posedge i_clk);
    endtask

    function automatic t_symbol pick_follower(input t_follow_mask m);
        t_symbol r;
        r = t_symbol'($urandom_range(0, 15));
        if (m == '0 || $urandom_range(0, 9) == 0) return r;
        while (!m[r]) r = t_symbol'($urandom_range(0, 15));
        return r;
    endfunction

    task automatic add_frame(input t_symbol f, input t_symbol e, input t_follow_mask m);
        int      body;
        t_symbol b;
        queue_symbol(f);
        queue_symbol(pick_follower(m));
        body = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
        repeat (body) begin
            b = t_symbol'($urandom_range(0, 15));
            if (b == f) queue_symbol(e);
            queue_symbol(b);
        end
        queue_symbol(f);
    endtask

    task automatic run_phase(input t_symbol f, input t_symbol e, input t_follow_mask m,
                             input int count, input logic snd_idle, input logic rcv_idle,
                             input logic with_hold);
        int base;
        int r;
        drain();
        load_config(f, e, m);
        send_idle_on = snd_idle;
        recv_idle_on = rcv_idle;
        base = symbol_feed.size();
        while (symbol_feed.size() - base < count) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                add_frame(f, e, m);
            end else if (r < 80) begin
                queue_symbol(f);
                queue_symbol(t_symbol'($urandom_range(0, 15)));
            end else if (r < 88) begin
                queue_symbol(e);
                queue_symbol(f);
            end else begin
                repeat ($urandom_range(1, 5))
                    queue_symbol(t_symbol'($urandom_range(0, 15)));
            end
        end
        if (with_hold) begin
            while (symbol_feed.size() > count - 30) @(posedge i_clk);
            hold_reqs++;
        end
    endtask

    initial begin
        t_symbol rf;
        t_symbol re;
        sym_errors      = 0;
        hold_reqs       = 0;
        send_idle_on    = 1'b1;
        recv_idle_on    = 1'b1;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_FLAG;
        i_cfg_data      = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: escaped flag in a frame, rejected starts,
        // escaped flag while hunting, rejected follower that is itself a flag
        symbol_feed = '{4'd15, 4'd4, 4'd0, 4'd14, 4'd15, 4'd3, 4'd15,
                        4'd15, 4'd2, 4'd14, 4'd15, 4'd7,
                        4'd15, 4'd15, 4'd8, 4'd9, 4'd15};
        drain();
        // follower that closes at once, first symbol after a frame
        load_config(4'd0, 4'd15, 16'hFFFF);
        symbol_feed = '{4'd0, 4'd0, 4'd0, 4'd15, 4'd0, 4'd0};
        drain();
        // flag equal to escape
        load_config(4'd3, 4'd3, 16'hFFFF);
        symbol_feed = '{4'd3, 4'd3, 4'd5, 4'd3, 4'd3, 4'd1, 4'd3};

        run_phase(FLAG_RESET, ESCAPE_RESET, FOLLOW_RESET, 300, 1'b1, 1'b1, 1'b0);
        run_phase(4'd0, 4'd15, 16'hFFFF, 300, 1'b0, 1'b1, 1'b1);
        run_phase(4'd15, 4'd0, 16'h0000, 40, 1'b1, 1'b1, 1'b0);
        drain();
        write_reg(CFG_SPARE, t_cfg_data'($urandom_range(0, 65535)));
        rf = t_symbol'($urandom_range(0, 15));
        run_phase(rf, rf, t_follow_mask'($urandom_range(0, 65535)) | (16'h1 << rf),
                  250, 1'b0, 1'b0, 1'b0);
        repeat (4) begin
            rf = t_symbol'($urandom_range(0, 15));
            re = t_symbol'($urandom_range(0, 15));
            run_phase(rf, re, t_follow_mask'($urandom_range(0, 65535))
                      | (16'h1 << $urandom_range(0, 15)), 250, 1'b1, 1'b1, 1'b0);
        end

        drain();
        repeat (6) @(posedge i_clk);
        if (sym_errors == 0 && frame_expect.size() == 0)
            $display("** escaped_flag_frame_splitter_core: PASSED **");
        else
            $display("** escaped_flag_frame_splitter_core: FAILED **");
        $finish;
    end
endmodule
